/* rtl/core/lane_vehicle_counter_speed_unit_macros.svh */
// Assertion macros for the files that check their own logic.
`ifndef LANE_VEHICLE_COUNTER_SPEED_UNIT_MACROS_SVH
`define LANE_VEHICLE_COUNTER_SPEED_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/lvcs_pkg.sv */
package lvcs_pkg;

  localparam int FRAME_RATE      = 25;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int LANES           = 3;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int FRAME_W = 32;
  localparam int TOTAL_W = 32;
  localparam int SPEED_W = 16;
  localparam int LANE_W  = 2;
  localparam int CFG_W   = 10;
  localparam int ADDR_W  = 3;

  localparam int ROW_DIFF_MAX = (1 << ROW_W) - 1;
  localparam int NUM_W = $clog2(ROW_DIFF_MAX * FRAME_RATE * (1 << SPEED_FRAC_BITS) + 1);
  localparam int CNT_W = $clog2(NUM_W);
  localparam int EXT_W = (NUM_W > SPEED_W) ? NUM_W : SPEED_W + 1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Output word layout.
  localparam int O_LANE_HIT  = 0;
  localparam int O_COUNTED   = O_LANE_HIT + LANE_W;
  localparam int O_TOTAL     = O_COUNTED + 1;
  localparam int O_SVALID    = O_TOTAL + TOTAL_W;
  localparam int O_SLANE     = O_SVALID + 1;
  localparam int O_SPEED     = O_SLANE + LANE_W;
  localparam int O_USED      = O_SPEED + SPEED_W;

  localparam logic [ADDR_W-1:0] REG_LANE_ONE_LEFT     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LANE_ONE_RIGHT    = 3'd1;
  localparam logic [ADDR_W-1:0] REG_LANE_TWO_RIGHT    = 3'd2;
  localparam logic [ADDR_W-1:0] REG_LANE_THREE_RIGHT  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_ENTRY_BAND_TOP    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_ENTRY_BAND_BOTTOM = 3'd5;
  localparam logic [ADDR_W-1:0] REG_EXIT_BAND_TOP     = 3'd6;
  localparam logic [ADDR_W-1:0] REG_EXIT_BAND_BOTTOM  = 3'd7;

  localparam logic [COL_W-1:0] RST_LANE_ONE_LEFT     = 10'd110;
  localparam logic [COL_W-1:0] RST_LANE_ONE_RIGHT    = 10'd174;
  localparam logic [COL_W-1:0] RST_LANE_TWO_RIGHT    = 10'd238;
  localparam logic [COL_W-1:0] RST_LANE_THREE_RIGHT  = 10'd302;
  localparam logic [ROW_W-1:0] RST_ENTRY_BAND_TOP    = 9'd140;
  localparam logic [ROW_W-1:0] RST_ENTRY_BAND_BOTTOM = 9'd160;
  localparam logic [ROW_W-1:0] RST_EXIT_BAND_TOP     = 9'd180;
  localparam logic [ROW_W-1:0] RST_EXIT_BAND_BOTTOM  = 9'd200;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic measure;
  } dp_status_t;

endpackage

/* rtl/core/lane_vehicle_counter_speed_unit.sv */
// Lane vehicle counter and speed unit.
// The input stream (s_tvalid, s_tready, s_tdata) carries one detected blob per
// word: its center column, bottom row and frame number. Each accepted word
// yields exactly one output word on the m_ stream, in order.
// A blob inside one of three lanes may count a car when it enters the entry
// band and may close a speed measurement when it reaches the exit band.
// From acceptance, the EVAL state evaluates the lane; when a speed is
// measured, a restoring divider then takes one quotient bit per cycle over
// 18 bits, and the EMIT state loads the output register once it is free.
// One word is in flight at a time: a new input word is accepted only after
// the current one has been loaded into the output register.
// A finished word waits in the output register while m_tready is low; the
// next input word can already be accepted then, and its result waits in the
// unit until the output register frees up.
// Configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wr_data; the user writes them only while the unit is idle, which the
// unit does not enforce. Synchronous reset restores the default lane and
// band limits, clears the car count and all lane measurements, drops m_tvalid.
`include "lane_vehicle_counter_speed_unit_macros.svh"

module lane_vehicle_counter_speed_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [lvcs_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [lvcs_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // center_col, bottom_row, frame_number, zero fill
  input  logic [lvcs_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // lane_hit, car_counted, car_total, speed_valid, speed_lane, speed_q4,
  // zero fill
  output logic [lvcs_pkg::OUT_DATA_W-1:0]    m_tdata
);

  lvcs_pkg::dp_cmd_t    cmd;
  lvcs_pkg::dp_status_t status;

  logic [lvcs_pkg::LANE_W-1:0]  chk_lane_hit;
  logic                         chk_counted;
  logic                         chk_svalid;
  logic [lvcs_pkg::LANE_W-1:0]  chk_slane;
  logic [lvcs_pkg::SPEED_W-1:0] chk_speed;

  lvcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lvcs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .out_data    (m_tdata),
    .cmd         (cmd),
    .status      (status)
  );

  assign chk_lane_hit = m_tdata[lvcs_pkg::O_LANE_HIT +: lvcs_pkg::LANE_W];
  assign chk_counted  = m_tdata[lvcs_pkg::O_COUNTED];
  assign chk_svalid   = m_tdata[lvcs_pkg::O_SVALID];
  assign chk_slane    = m_tdata[lvcs_pkg::O_SLANE +: lvcs_pkg::LANE_W];
  assign chk_speed    = m_tdata[lvcs_pkg::O_SPEED +: lvcs_pkg::SPEED_W];

  `ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_idle_speed_zero, clk, rst, m_tvalid && !chk_svalid,
               chk_speed == '0 && chk_slane == '0)
  `ASSERT_IMPL(a_count_in_lane, clk, rst, m_tvalid && chk_counted, chk_lane_hit != '0)
  `ASSERT_IMPL(a_speed_lane_match, clk, rst, m_tvalid && chk_svalid,
               chk_lane_hit == chk_slane + 2'd1)

endmodule

/* rtl/core/lvcs_ctrl.sv */
module lvcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output lvcs_pkg::dp_cmd_t    cmd,
  input  lvcs_pkg::dp_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic [lvcs_pkg::CNT_W-1:0] step_cnt;
  logic                       out_free;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = s_tready && s_tvalid;
    cmd.eval     = (state == ST_EVAL);
    cmd.div_step = (state == ST_DIVIDE);
    cmd.emit     = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (status.measure) begin
            step_cnt <= lvcs_pkg::CNT_W'(lvcs_pkg::NUM_W - 1);
            state    <= ST_DIVIDE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_DIVIDE: begin
          if (step_cnt == '0) begin
            state <= ST_EMIT;
          end else begin
            step_cnt <= step_cnt - 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/lvcs_datapath.sv */
module lvcs_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lvcs_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [lvcs_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic [lvcs_pkg::IN_DATA_W-1:0]      in_data,
  output logic [lvcs_pkg::OUT_DATA_W-1:0]     out_data,
  input  lvcs_pkg::dp_cmd_t                   cmd,
  output lvcs_pkg::dp_status_t                status
);

  localparam int COL_W   = lvcs_pkg::COL_W;
  localparam int ROW_W   = lvcs_pkg::ROW_W;
  localparam int FRAME_W = lvcs_pkg::FRAME_W;
  localparam int NUM_W   = lvcs_pkg::NUM_W;
  localparam int LANE_W  = lvcs_pkg::LANE_W;

  logic [COL_W-1:0] lane_one_left;
  logic [COL_W-1:0] lane_one_right;
  logic [COL_W-1:0] lane_two_right;
  logic [COL_W-1:0] lane_three_right;
  logic [ROW_W-1:0] entry_band_top;
  logic [ROW_W-1:0] entry_band_bottom;
  logic [ROW_W-1:0] exit_band_top;
  logic [ROW_W-1:0] exit_band_bottom;

  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [FRAME_W-1:0] frame_q;

  logic [lvcs_pkg::TOTAL_W-1:0] car_tally;
  logic [lvcs_pkg::LANES-1:0]   entry_seen;
  logic [lvcs_pkg::LANES-1:0]   exit_seen;
  logic [lvcs_pkg::LANES-1:0]   start_valid;
  logic [ROW_W-1:0]             start_row   [lvcs_pkg::LANES];
  logic [FRAME_W-1:0]           start_frame [lvcs_pkg::LANES];
  logic [ROW_W-1:0]             end_row     [lvcs_pkg::LANES];
  logic [FRAME_W-1:0]           end_frame   [lvcs_pkg::LANES];

  logic [LANE_W-1:0] res_lane_hit;
  logic              res_counted;
  logic              res_svalid;
  logic [LANE_W-1:0] res_slane;

  logic [NUM_W-1:0]   num_q;
  logic [FRAME_W-1:0] divisor;
  logic [FRAME_W-1:0] rem;
  logic               div_zero;

  logic [LANE_W-1:0]           out_lane_hit;
  logic                        out_counted;
  logic [lvcs_pkg::TOTAL_W-1:0] out_total;
  logic                        out_svalid;
  logic [LANE_W-1:0]           out_slane;
  logic [lvcs_pkg::SPEED_W-1:0] out_speed;

  logic               hit0, hit1, hit2, in_lane;
  logic [LANE_W-1:0]  lane;
  logic               do_entry, in_exit, do_exit_band, do_exit;
  logic               sv_new;
  logic [ROW_W-1:0]   sr_new, er_new, row_diff;
  logic [FRAME_W-1:0] sf_new, ef_new, frame_diff;
  logic               measure;
  logic [NUM_W-1:0]   num_load;
  logic [FRAME_W:0]   rem_shift;
  logic               q_bit;
  logic [lvcs_pkg::SPEED_W-1:0] speed_sat;

  always_comb begin
    hit0    = (col_q > lane_one_left) && (col_q <= lane_one_right);
    hit1    = (col_q > lane_one_right) && (col_q <= lane_two_right);
    hit2    = (col_q > lane_two_right) && (col_q <= lane_three_right);
    in_lane = hit0 || hit1 || hit2;
    if (hit0) begin
      lane = 2'd0;
    end else if (hit1) begin
      lane = 2'd1;
    end else begin
      lane = 2'd2;
    end
    do_entry = !entry_seen[lane] && (row_q >= entry_band_top) &&
               (row_q <= entry_band_bottom);
    sv_new = do_entry ? 1'b1 : start_valid[lane];
    sr_new = do_entry ? row_q : start_row[lane];
    sf_new = do_entry ? frame_q : start_frame[lane];
    in_exit      = (row_q >= exit_band_top) && (row_q <= exit_band_bottom);
    do_exit_band = !exit_seen[lane] && in_exit;
    do_exit      = do_exit_band && sv_new;
    er_new = do_exit ? row_q : end_row[lane];
    ef_new = do_exit ? frame_q : end_frame[lane];
    measure    = in_lane && (er_new > sr_new);
    row_diff   = er_new - sr_new;
    frame_diff = ef_new - sf_new;
    num_load   = (NUM_W'(row_diff) * NUM_W'(lvcs_pkg::FRAME_RATE))
                 << lvcs_pkg::SPEED_FRAC_BITS;
  end

  assign status.measure = measure;

  assign rem_shift = {rem, num_q[NUM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  always_comb begin
    if (div_zero ||
        (lvcs_pkg::EXT_W'(num_q) > lvcs_pkg::EXT_W'(lvcs_pkg::SPEED_MAX))) begin
      speed_sat = lvcs_pkg::SPEED_MAX;
    end else begin
      speed_sat = lvcs_pkg::SPEED_W'(num_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_one_left     <= lvcs_pkg::RST_LANE_ONE_LEFT;
      lane_one_right    <= lvcs_pkg::RST_LANE_ONE_RIGHT;
      lane_two_right    <= lvcs_pkg::RST_LANE_TWO_RIGHT;
      lane_three_right  <= lvcs_pkg::RST_LANE_THREE_RIGHT;
      entry_band_top    <= lvcs_pkg::RST_ENTRY_BAND_TOP;
      entry_band_bottom <= lvcs_pkg::RST_ENTRY_BAND_BOTTOM;
      exit_band_top     <= lvcs_pkg::RST_EXIT_BAND_TOP;
      exit_band_bottom  <= lvcs_pkg::RST_EXIT_BAND_BOTTOM;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        lvcs_pkg::REG_LANE_ONE_LEFT:     lane_one_left     <= cfg_wr_data;
        lvcs_pkg::REG_LANE_ONE_RIGHT:    lane_one_right    <= cfg_wr_data;
        lvcs_pkg::REG_LANE_TWO_RIGHT:    lane_two_right    <= cfg_wr_data;
        lvcs_pkg::REG_LANE_THREE_RIGHT:  lane_three_right  <= cfg_wr_data;
        lvcs_pkg::REG_ENTRY_BAND_TOP:    entry_band_top    <= ROW_W'(cfg_wr_data);
        lvcs_pkg::REG_ENTRY_BAND_BOTTOM: entry_band_bottom <= ROW_W'(cfg_wr_data);
        lvcs_pkg::REG_EXIT_BAND_TOP:     exit_band_top     <= ROW_W'(cfg_wr_data);
        lvcs_pkg::REG_EXIT_BAND_BOTTOM:  exit_band_bottom  <= ROW_W'(cfg_wr_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q   <= in_data[COL_W-1:0];
      row_q   <= in_data[COL_W +: ROW_W];
      frame_q <= in_data[COL_W+ROW_W +: FRAME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car_tally   <= '0;
      entry_seen  <= '0;
      exit_seen   <= '0;
      start_valid <= '0;
      for (int i = 0; i < lvcs_pkg::LANES; i++) begin
        start_row[i]   <= '0;
        start_frame[i] <= '0;
        end_row[i]     <= '0;
        end_frame[i]   <= '0;
      end
    end else if (cmd.eval && in_lane) begin
      if (do_entry) begin
        car_tally        <= car_tally + 1'b1;
        entry_seen[lane] <= 1'b1;
      end else if (row_q > entry_band_bottom) begin
        entry_seen[lane] <= 1'b0;
      end
      if (do_exit_band) begin
        if (sv_new) begin
          exit_seen[lane] <= 1'b1;
        end
      end else if (row_q > exit_band_bottom) begin
        exit_seen[lane] <= 1'b0;
      end
      if (measure) begin
        start_valid[lane] <= 1'b0;
        start_row[lane]   <= '0;
        start_frame[lane] <= '0;
        end_row[lane]     <= '0;
        end_frame[lane]   <= '0;
      end else begin
        start_valid[lane] <= sv_new;
        start_row[lane]   <= sr_new;
        start_frame[lane] <= sf_new;
        end_row[lane]     <= er_new;
        end_frame[lane]   <= ef_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_lane_hit <= in_lane ? lane + 1'b1 : '0;
      res_counted  <= in_lane && do_entry;
      res_svalid   <= measure;
      res_slane    <= measure ? lane : '0;
      num_q        <= num_load;
      divisor      <= frame_diff;
      div_zero     <= (frame_diff == '0);
      rem          <= '0;
    end else if (cmd.div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem   <= q_bit ? FRAME_W'(rem_shift - {1'b0, divisor}) : FRAME_W'(rem_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_lane_hit <= res_lane_hit;
      out_counted  <= res_counted;
      out_total    <= car_tally;
      out_svalid   <= res_svalid;
      out_slane    <= res_slane;
      out_speed    <= res_svalid ? speed_sat : '0;
    end
  end

  assign out_data = {{(lvcs_pkg::OUT_DATA_W - lvcs_pkg::O_USED){1'b0}},
                     out_speed, out_slane, out_svalid, out_total, out_counted,
                     out_lane_hit};

endmodule
